/* sv/tjaik_pkg.sv */
// ----------------------------------------------------------------------------
// tjaik_pkg
// shared widths, angle constants, status and register codes for the arm solver
// ----------------------------------------------------------------------------
`default_nettype none

package tjaik_pkg;

	// fixed point and cordic setup
	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 18;

	// cordic lane width and angle accumulator width (q30 radians)
	localparam int CW = 48;
	localparam int ZW = 34;

	// pipelined square root: one root bit per stage
	localparam int SQ_IN_W  = 56;
	localparam int SQ_OUT_W = SQ_IN_W / 2;
	localparam int SQ_LAT   = SQ_OUT_W;

	// normalize steps, then quadrant fold, then micro-rotations
	localparam int NORM_STEPS = 7;
	localparam int CORDIC_LAT = NORM_STEPS + CORDIC_STAGES + 2;

	// rounding from q30 to the output fraction
	localparam int RND_SH = 30 - FRAC_BITS;
	localparam int FR_W   = 21;

	localparam longint PI_Q30_L         = 64'sd3373259426;
	localparam longint HALF_PI_Q30_L    = 64'sd1686629713;
	localparam longint THREE_HALF_Q30_L = 64'sd5059889139;
	localparam longint ROUND_L          = 64'sd1 <<< (RND_SH - 1);

	localparam logic signed [ZW-1:0] PI_Q30      = ZW'(PI_Q30_L);
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(HALF_PI_Q30_L);
	localparam logic signed [ZW:0]   ROUND_Q30   = (ZW+1)'(ROUND_L);

	localparam logic signed [FR_W-1:0] PI_F =
		FR_W'((PI_Q30_L + ROUND_L) >>> RND_SH);
	localparam logic signed [FR_W-1:0] HALF_PI_F =
		FR_W'((HALF_PI_Q30_L + ROUND_L) >>> RND_SH);
	localparam logic signed [FR_W-1:0] THREE_HALF_PI_F =
		FR_W'((THREE_HALF_Q30_L + ROUND_L) >>> RND_SH);
	localparam logic signed [FR_W-1:0] ELBOW_C =
		FR_W'(((64'sd314159 <<< FRAC_BITS) + 64'sd50000) / 64'sd100000);

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_REACH    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
	localparam logic [1:0] REG_UPPER_LINK  = 2'd1;
	localparam logic [1:0] REG_FOREARM     = 2'd2;

	// atan(2^-i) in q30
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		case (i)
			0:  return ZW'(64'sd843314856);
			1:  return ZW'(64'sd497837829);
			2:  return ZW'(64'sd263043836);
			3:  return ZW'(64'sd133525158);
			4:  return ZW'(64'sd67021686);
			5:  return ZW'(64'sd33543515);
			6:  return ZW'(64'sd16775850);
			7:  return ZW'(64'sd8388437);
			8:  return ZW'(64'sd4194282);
			9:  return ZW'(64'sd2097149);
			10: return ZW'(64'sd1048575);
			11: return ZW'(64'sd524287);
			12: return ZW'(64'sd262143);
			13: return ZW'(64'sd131071);
			14: return ZW'(64'sd65535);
			15: return ZW'(64'sd32767);
			16: return ZW'(64'sd16383);
			17: return ZW'(64'sd8191);
			18: return ZW'(64'sd4095);
			19: return ZW'(64'sd2047);
			20: return ZW'(64'sd1023);
			21: return ZW'(64'sd511);
			22: return ZW'(64'sd255);
			23: return ZW'(64'sd127);
			24: return ZW'(64'sd63);
			25: return ZW'(64'sd31);
			26: return ZW'(64'sd15);
			27: return ZW'(64'sd7);
			default: return '0;
		endcase
	endfunction

	// normalize step k shifts left by norm_shift(k) while magnitude < 2^norm_exp(k)
	function automatic int norm_shift(input int k);
		case (k)
			0: return 32;
			1: return 16;
			2: return 8;
			3: return 4;
			4: return 2;
			default: return 1;
		endcase
	endfunction

	function automatic int norm_exp(input int k);
		case (k)
			0: return 8;
			1: return 24;
			2: return 32;
			3: return 36;
			4: return 38;
			5: return 39;
			default: return 40;
		endcase
	endfunction

endpackage

`default_nettype wire

/* sv/tjaik_isqrt.sv */
// ----------------------------------------------------------------------------
// tjaik_isqrt
// pipelined integer square root, floor result, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module tjaik_isqrt (
	input  wire                              clk,
	input  wire                              en,
	input  wire  [tjaik_pkg::SQ_IN_W-1:0]    rad,
	output logic [tjaik_pkg::SQ_OUT_W-1:0]   root
);
	import tjaik_pkg::*;

	logic [SQ_IN_W-1:0] rem_s [SQ_LAT+1];
	logic [SQ_IN_W:0]   acc_s [SQ_LAT+1];

	assign rem_s[0] = rad;
	assign acc_s[0] = '0;

	for (genvar k = 0; k < SQ_LAT; k++) begin : g_bit
		localparam logic [SQ_IN_W:0] B = (SQ_IN_W+1)'(1) << (2 * (SQ_LAT - 1 - k));
		logic [SQ_IN_W:0] trial;
		assign trial = acc_s[k] + B;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[k]} >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial[SQ_IN_W-1:0];
					acc_s[k+1] <= (acc_s[k] >> 1) + B;
				end else begin
					rem_s[k+1] <= rem_s[k];
					acc_s[k+1] <= acc_s[k] >> 1;
				end
			end
		end
	end

	assign root = acc_s[SQ_LAT][SQ_OUT_W-1:0];

endmodule

`default_nettype wire

/* sv/tjaik_cordic.sv */
// ----------------------------------------------------------------------------
// tjaik_cordic
// pipelined vectoring cordic: atan2(y, x) in q30 radians
// ----------------------------------------------------------------------------
`default_nettype none

module tjaik_cordic (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire  signed [tjaik_pkg::CW-1:0]      x_in,
	input  wire  signed [tjaik_pkg::CW-1:0]      y_in,
	output logic signed [tjaik_pkg::ZW-1:0]      z_out
);
	import tjaik_pkg::*;

	// flag bit 1: y was zero, bit 0: x was negative
	logic signed [CW-1:0] nx [NORM_STEPS+1];
	logic signed [CW-1:0] ny [NORM_STEPS+1];
	logic        [CW-1:0] nm [NORM_STEPS+1];
	logic        [1:0]    nf [NORM_STEPS+1];

	logic signed [CW-1:0] cx [CORDIC_STAGES+1];
	logic signed [CW-1:0] cy [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
	logic        [1:0]    cf [CORDIC_STAGES+1];

	logic [CW-1:0] ax, ay;

	assign ax = x_in[CW-1] ? CW'(-x_in) : CW'(x_in);
	assign ay = y_in[CW-1] ? CW'(-y_in) : CW'(y_in);

	// magnitude capture
	always_ff @(posedge clk) begin
		if (en) begin
			nx[0] <= x_in;
			ny[0] <= y_in;
			nm[0] <= (ax > ay) ? ax : ay;
			nf[0] <= {(y_in == '0), x_in[CW-1]};
		end
	end

	// scale up until the larger magnitude reaches 2^40
	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		localparam int E = norm_exp(k);
		localparam int S = norm_shift(k);

		always_ff @(posedge clk) begin
			if (en) begin
				if (nm[k][CW-1:E] == '0) begin
					nx[k+1] <= nx[k] <<< S;
					ny[k+1] <= ny[k] <<< S;
					nm[k+1] <= nm[k] << S;
				end else begin
					nx[k+1] <= nx[k];
					ny[k+1] <= ny[k];
					nm[k+1] <= nm[k];
				end
				nf[k+1] <= nf[k];
			end
		end
	end

	// fold left half plane into the right
	always_ff @(posedge clk) begin
		if (en) begin
			cf[0] <= nf[NORM_STEPS];
			if (nx[NORM_STEPS][CW-1]) begin
				if (!ny[NORM_STEPS][CW-1] && ny[NORM_STEPS] != '0) begin
					cx[0] <= ny[NORM_STEPS];
					cy[0] <= -nx[NORM_STEPS];
					cz[0] <= HALF_PI_Q30;
				end else begin
					cx[0] <= -ny[NORM_STEPS];
					cy[0] <= nx[NORM_STEPS];
					cz[0] <= -HALF_PI_Q30;
				end
			end else begin
				cx[0] <= nx[NORM_STEPS];
				cy[0] <= ny[NORM_STEPS];
				cz[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		localparam logic signed [ZW-1:0] AT = atan_q30(i);
		logic signed [CW-1:0] xs, ys;

		assign xs = cx[i] >>> i;
		assign ys = cy[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy[i][CW-1] && cy[i] != '0) begin
					cx[i+1] <= cx[i] + ys;
					cy[i+1] <= cy[i] - xs;
					cz[i+1] <= cz[i] + AT;
				end else begin
					cx[i+1] <= cx[i] - ys;
					cy[i+1] <= cy[i] + xs;
					cz[i+1] <= cz[i] - AT;
				end
				cf[i+1] <= cf[i];
			end
		end
	end

	// y of zero gives exactly 0 or pi
	always_comb begin
		if (cf[CORDIC_STAGES][1])
			z_out = cf[CORDIC_STAGES][0] ? PI_Q30 : '0;
		else
			z_out = cz[CORDIC_STAGES];
	end

endmodule

`default_nettype wire

/* sv/three_joint_arm_inverse_kinematics_top.sv */
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics_top
// geometric inverse kinematics for a base / shoulder / elbow arm
// ----------------------------------------------------------------------------
// Takes one target point (x, y, z, signed q4.16) per transfer and returns the
// base, shoulder, elbow angles (signed q3.16, q4.16, q3.16 radians) and a status code.
// The datapath is a 92-stage pipeline: input capture and squaring (4 stages),
// a bit-per-stage square root of the squared reach and of the horizontal
// distance (28), the triangle factors and their products (2), a second pair of
// square roots for the Heron area (28), the area product (1), four parallel
// vectoring cordic lanes (27: magnitude, seven normalize steps, quadrant fold,
// 18 micro-rotations), rounding (1) and the output register (1). A new target
// is taken every cycle while the pipeline is not held. The whole pipeline
// advances together: it holds only while a result sits in the output
// register and out_ready is low, so in_ready is low then.
// Status 1 flags x = z = 0, status 2 a target out of reach (or a zero link);
// in both cases the angles are zero. Configuration writes land at once and
// must be made while no target is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module three_joint_arm_inverse_kinematics_top (
	input  wire               clk,
	input  wire               arst_n,

	// configuration write port
	input  wire               cfg_we,
	input  wire  [1:0]        cfg_index,
	input  wire  [18:0]       cfg_data,

	// target transfer
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  signed [19:0] target_x,
	input  wire  signed [19:0] target_y,
	input  wire  signed [19:0] target_z,

	// angle transfer
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [18:0] base_angle,
	output logic signed [19:0] shoulder_angle,
	output logic signed [18:0] elbow_angle,
	output logic [1:0]        solve_status
);
	import tjaik_pkg::*;

	// payload carried alongside the first root
	typedef struct packed {
		logic [1:0]         status;
		logic signed [19:0] x;
		logic signed [19:0] z;
		logic signed [20:0] r1;
		logic [40:0]        rr2;
	} d1_t;

	// payload carried alongside the area roots
	typedef struct packed {
		logic [1:0]         status;
		logic signed [19:0] x;
		logic signed [19:0] z;
		logic signed [20:0] r1;
		logic [27:0]        r0q;
		logic signed [42:0] n1;
		logic signed [42:0] n2;
	} d2_t;

	function automatic logic signed [FR_W-1:0] to_frac(input logic signed [ZW:0] v);
		logic signed [ZW:0] t;
		t = v + ROUND_Q30;
		return FR_W'(t >>> RND_SH);
	endfunction

	function automatic logic signed [FR_W-1:0] clamp(input logic signed [FR_W-1:0] v,
			input logic signed [FR_W-1:0] lo, input logic signed [FR_W-1:0] hi);
		if (v < lo)
			return lo;
		else if (v > hi)
			return hi;
		return v;
	endfunction

	logic adv;

	// configuration registers
	logic [18:0] base_height_q, upper_link_q, forearm_q;

	// link geometry derived from configuration
	logic [19:0]        sum_q;
	logic [18:0]        dif_q;
	logic [39:0]        sumsq_q;
	logic [37:0]        difsq_q, l1sq_q, l2sq_q;
	logic signed [38:0] k1_q;
	logic [38:0]        k2_q;
	logic               lzero_q;

	// front stages
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [19:0] x_s1, y_s1, z_s1;
	logic signed [19:0] x_s2, z_s2, x_s3, z_s3, x_s4, z_s4;
	logic signed [20:0] r1_s2, r1_s3, r1_s4;
	logic               sing_s2, sing_s3, sing_s4;
	logic [38:0]        xx_s2, zz_s2;
	logic [39:0]        rr0_s3, rr0_s4;
	logic [40:0]        r1sq_s3, rr2_s4;

	logic signed [39:0] xsq, zsq;
	logic signed [41:0] r1sq;
	logic               oor;
	logic [1:0]         status_s4;

	// first root section
	logic [SQ_OUT_W-1:0] root_a, root_b;
	logic                d1_v [SQ_LAT];
	d1_t                 d1   [SQ_LAT];

	// triangle factors and products
	logic               v_s5, v_s6;
	logic [21:0]        f1_s5, f2_s5, f3_s5, f4_s5;
	logic [43:0]        p_s6, q_s6;
	d2_t                pl_s5, pl_s6;
	logic signed [22:0] l1x, l2x, cx, f1, f2, f3, f4;

	// area roots
	logic [SQ_OUT_W-1:0] root_c, root_d;
	logic                d2_v [SQ_LAT];
	d2_t                 d2   [SQ_LAT];

	// area product and cordic lanes
	logic               v_s7;
	logic [43:0]        s_s7;
	d2_t                pl_s7;
	logic signed [ZW-1:0] z0, z1, z2, z3;
	logic               d3_v [CORDIC_LAT];
	logic [1:0]         d3   [CORDIC_LAT];

	// rounding stage
	logic               v_s8;
	logic [1:0]         status_s8;
	logic signed [FR_W-1:0] a0_s8, a1_s8, a2_s8;
	logic signed [ZW:0] zsum;
	logic signed [FR_W-1:0] b_c, s_c, e_c, e_raw;

	// whole pipe moves unless a finished result is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= '0;
			upper_link_q  <= 19'(1 << FRAC_BITS);
			forearm_q     <= 19'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_HEIGHT: base_height_q <= cfg_data;
				REG_UPPER_LINK:  upper_link_q  <= cfg_data;
				REG_FOREARM:     forearm_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// refreshed every cycle: sum, difference, link squares and zero flag from the configuration, the rest from those
	always_ff @(posedge clk) begin
		sum_q   <= {1'b0, upper_link_q} + {1'b0, forearm_q};
		dif_q   <= (upper_link_q > forearm_q) ? upper_link_q - forearm_q
		                                      : forearm_q - upper_link_q;
		l1sq_q  <= upper_link_q * upper_link_q;
		l2sq_q  <= forearm_q * forearm_q;
		lzero_q <= (upper_link_q == '0) || (forearm_q == '0);
		sumsq_q <= sum_q * sum_q;
		difsq_q <= dif_q * dif_q;
		k1_q    <= $signed({1'b0, l1sq_q}) - $signed({1'b0, l2sq_q});
		k2_q    <= {1'b0, l1sq_q} + {1'b0, l2sq_q};
	end

	// ------------------------------------------------------------------
	// valid bits
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < SQ_LAT; i++) begin
				d1_v[i] <= 1'b0;
				d2_v[i] <= 1'b0;
			end
			for (int i = 0; i < CORDIC_LAT; i++)
				d3_v[i] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			d1_v[0] <= v_s4;
			for (int i = 1; i < SQ_LAT; i++)
				d1_v[i] <= d1_v[i-1];
			v_s5 <= d1_v[SQ_LAT-1];
			v_s6 <= v_s5;
			d2_v[0] <= v_s6;
			for (int i = 1; i < SQ_LAT; i++)
				d2_v[i] <= d2_v[i-1];
			v_s7 <= d2_v[SQ_LAT-1];
			d3_v[0] <= v_s7;
			for (int i = 1; i < CORDIC_LAT; i++)
				d3_v[i] <= d3_v[i-1];
			v_s8 <= d3_v[CORDIC_LAT-1];
			out_valid <= v_s8;
		end
	end

	// ------------------------------------------------------------------
	// squares and reach test
	// ------------------------------------------------------------------
	assign xsq  = x_s1 * x_s1;
	assign zsq  = z_s1 * z_s1;
	assign r1sq = r1_s2 * r1_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= target_x;
			y_s1 <= target_y;
			z_s1 <= target_z;

			x_s2    <= x_s1;
			z_s2    <= z_s1;
			sing_s2 <= (x_s1 == '0) && (z_s1 == '0);
			xx_s2   <= xsq[38:0];
			zz_s2   <= zsq[38:0];
			r1_s2   <= {y_s1[19], y_s1} - $signed({2'b00, base_height_q});

			x_s3    <= x_s2;
			z_s3    <= z_s2;
			r1_s3   <= r1_s2;
			sing_s3 <= sing_s2;
			rr0_s3  <= {1'b0, xx_s2} + {1'b0, zz_s2};
			r1sq_s3 <= r1sq[40:0];

			x_s4    <= x_s3;
			z_s4    <= z_s3;
			r1_s4   <= r1_s3;
			sing_s4 <= sing_s3;
			rr0_s4  <= rr0_s3;
			rr2_s4  <= {1'b0, rr0_s3} + r1sq_s3;
		end
	end

	assign oor = lzero_q || (rr2_s4 > {1'b0, sumsq_q}) || (rr2_s4 < {3'b000, difsq_q});
	assign status_s4 = sing_s4 ? ST_SINGULAR : (oor ? ST_REACH : ST_OK);

	// ------------------------------------------------------------------
	// reach root and horizontal distance root
	// ------------------------------------------------------------------
	tjaik_isqrt u_sqrt_reach (
		.clk  (clk),
		.en   (adv),
		.rad  (SQ_IN_W'(rr2_s4)),
		.root (root_a)
	);

	tjaik_isqrt u_sqrt_horiz (
		.clk  (clk),
		.en   (adv),
		.rad  ({rr0_s4, 16'd0}),
		.root (root_b)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			d1[0] <= '{status: status_s4, x: x_s4, z: z_s4, r1: r1_s4, rr2: rr2_s4};
			for (int i = 1; i < SQ_LAT; i++)
				d1[i] <= d1[i-1];
		end
	end

	// ------------------------------------------------------------------
	// heron factors and law of cosines numerators
	// ------------------------------------------------------------------
	assign l1x = {4'b0000, upper_link_q};
	assign l2x = {4'b0000, forearm_q};
	assign cx  = {2'b00, root_a[20:0]};
	assign f1  = l1x + l2x + cx;
	assign f2  = l2x + cx - l1x;
	assign f3  = l1x + cx - l2x;
	assign f4  = l1x + l2x - cx;

	always_ff @(posedge clk) begin
		if (adv) begin
			f1_s5 <= f1[21:0];
			f2_s5 <= f2[22] ? '0 : f2[21:0];
			f3_s5 <= f3[22] ? '0 : f3[21:0];
			f4_s5 <= f4[22] ? '0 : f4[21:0];
			pl_s5.status <= d1[SQ_LAT-1].status;
			pl_s5.x      <= d1[SQ_LAT-1].x;
			pl_s5.z      <= d1[SQ_LAT-1].z;
			pl_s5.r1     <= d1[SQ_LAT-1].r1;
			pl_s5.r0q    <= root_b;
			pl_s5.n1     <= {{4{k1_q[38]}}, k1_q} + $signed({2'b00, d1[SQ_LAT-1].rr2});
			pl_s5.n2     <= $signed({4'b0000, k2_q}) - $signed({2'b00, d1[SQ_LAT-1].rr2});

			p_s6  <= f1_s5 * f2_s5;
			q_s6  <= f3_s5 * f4_s5;
			pl_s6 <= pl_s5;
		end
	end

	// ------------------------------------------------------------------
	// area roots
	// ------------------------------------------------------------------
	tjaik_isqrt u_sqrt_p (
		.clk  (clk),
		.en   (adv),
		.rad  (SQ_IN_W'(p_s6)),
		.root (root_c)
	);

	tjaik_isqrt u_sqrt_q (
		.clk  (clk),
		.en   (adv),
		.rad  (SQ_IN_W'(q_s6)),
		.root (root_d)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			d2[0] <= pl_s6;
			for (int i = 1; i < SQ_LAT; i++)
				d2[i] <= d2[i-1];
			s_s7  <= root_c[21:0] * root_d[21:0];
			pl_s7 <= d2[SQ_LAT-1];
		end
	end

	// ------------------------------------------------------------------
	// angle lanes: base, shoulder cosine part, shoulder tilt, elbow
	// ------------------------------------------------------------------
	tjaik_cordic u_cordic_base (
		.clk   (clk),
		.en    (adv),
		.x_in  (CW'(pl_s7.x)),
		.y_in  (-CW'(pl_s7.z)),
		.z_out (z0)
	);

	tjaik_cordic u_cordic_shoulder (
		.clk   (clk),
		.en    (adv),
		.x_in  (CW'(pl_s7.n1)),
		.y_in  ($signed(CW'(s_s7))),
		.z_out (z1)
	);

	tjaik_cordic u_cordic_tilt (
		.clk   (clk),
		.en    (adv),
		.x_in  ($signed(CW'(pl_s7.r0q))),
		.y_in  (CW'(pl_s7.r1) <<< 8),
		.z_out (z2)
	);

	tjaik_cordic u_cordic_elbow (
		.clk   (clk),
		.en    (adv),
		.x_in  (CW'(pl_s7.n2)),
		.y_in  ($signed(CW'(s_s7))),
		.z_out (z3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			d3[0] <= pl_s7.status;
			for (int i = 1; i < CORDIC_LAT; i++)
				d3[i] <= d3[i-1];
		end
	end

	// ------------------------------------------------------------------
	// rounding, clamping and output register
	// ------------------------------------------------------------------
	assign zsum = {z1[ZW-1], z1} + {z2[ZW-1], z2};

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s8 <= d3[CORDIC_LAT-1];
			a0_s8     <= to_frac({z0[ZW-1], z0});
			a1_s8     <= to_frac(zsum);
			a2_s8     <= to_frac({z3[ZW-1], z3});
		end
	end

	assign b_c   = clamp(a0_s8, -PI_F, PI_F);
	assign s_c   = clamp(a1_s8, -HALF_PI_F, THREE_HALF_PI_F);
	assign e_raw = a2_s8 - ELBOW_C;
	assign e_c   = clamp(e_raw, -ELBOW_C, '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			solve_status <= status_s8;
			if (status_s8 == ST_OK) begin
				base_angle     <= b_c[18:0];
				shoulder_angle <= s_c[19:0];
				elbow_angle    <= e_c[18:0];
			end else begin
				base_angle     <= '0;
				shoulder_angle <= '0;
				elbow_angle    <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	// flagged results carry zero angles
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && solve_status != ST_OK |->
			base_angle == '0 && shoulder_angle == '0 && elbow_angle == '0)
		else $error("flagged result with nonzero angle");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> solve_status == ST_OK || solve_status == ST_SINGULAR ||
			solve_status == ST_REACH)
		else $error("undefined status code");

	// elbow folds one way only
	a_elbow_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> elbow_angle <= 19'sd0)
		else $error("elbow angle positive");

	// base stays within half a turn
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> base_angle <= $signed(PI_F[18:0]) &&
			base_angle >= -$signed(PI_F[18:0]))
		else $error("base angle out of range");
`endif

endmodule

`default_nettype wire

/* tb/tjaik_checker.sv */
// ----------------------------------------------------------------------------
// tjaik_checker
// watches the config port and both channels of the arm solver, predicts the
// joint angles of every accepted target and compares them with the results
// ----------------------------------------------------------------------------
`default_nettype none

module tjaik_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [1:0]        cfg_index,
	input  wire  [18:0]       cfg_data,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire  signed [19:0] target_x,
	input  wire  signed [19:0] target_y,
	input  wire  signed [19:0] target_z,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire  signed [18:0] base_angle,
	input  wire  signed [19:0] shoulder_angle,
	input  wire  signed [18:0] elbow_angle,
	input  wire  [1:0]        solve_status,
	output int                fail_count,
	output int                angles_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tjaik_pkg::*;

	typedef struct packed {
		logic signed [18:0] base;
		logic signed [19:0] shoulder;
		logic signed [18:0] elbow;
		logic [1:0]         status;
	} joint_set_t;

	joint_set_t angle_queue[$];
	longint     height_q, upper_q, fore_q;

	function automatic longint unsigned sqrt_floor(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// atan2(y, x) in q30 by vectoring rotations
	function automatic longint cordic_angle(input longint x, input longint y);
		longint acc, t, xs, ys;
		longint lim;
		acc = 0;
		lim = 64'sd1 <<< 40;
		if (y == 0)
			return (x >= 0) ? 0 : PI_Q30_L;
		while (x < lim && x > -lim && y < lim && y > -lim) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			t = x;
			if (y > 0) begin
				x = y; y = -t; acc = HALF_PI_Q30_L;
			end else begin
				x = -y; y = t; acc = -HALF_PI_Q30_L;
			end
		end
		for (int i = 0; i < CORDIC_STAGES && i < 28; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; acc += longint'(atan_q30(i));
			end else begin
				x -= ys; y += xs; acc -= longint'(atan_q30(i));
			end
		end
		return acc;
	endfunction

	function automatic longint round_to_frac(input longint q);
		return (q + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic joint_set_t solve_arm(input longint x, input longint y,
			input longint z);
		joint_set_t r;
		longint rr0, r1, rr2, sum, dif, c, f1, f2, f3, f4, p, q, s, n1, n2, r0q;
		longint pi_f, elbow_c, a0, a1, a2;
		r = '0;
		pi_f = round_to_frac(PI_Q30_L);
		elbow_c = ((64'sd314159 <<< FRAC_BITS) + 50000) / 100000;
		if (x == 0 && z == 0) begin
			r.status = ST_SINGULAR;
			return r;
		end
		rr0 = x * x + z * z;
		r1 = y - height_q;
		rr2 = rr0 + r1 * r1;
		sum = upper_q + fore_q;
		dif = (upper_q > fore_q) ? upper_q - fore_q : fore_q - upper_q;
		if (upper_q == 0 || fore_q == 0 || rr2 > sum * sum || rr2 < dif * dif) begin
			r.status = ST_REACH;
			return r;
		end
		c = longint'(sqrt_floor(rr2));
		f1 = upper_q + fore_q + c;
		f2 = fore_q + c - upper_q;
		f3 = upper_q + c - fore_q;
		f4 = upper_q + fore_q - c;
		if (f2 < 0) f2 = 0;
		if (f3 < 0) f3 = 0;
		if (f4 < 0) f4 = 0;
		p = f1 * f2;
		q = f3 * f4;
		s = longint'(sqrt_floor(p) * sqrt_floor(q));
		n1 = upper_q * upper_q + rr2 - fore_q * fore_q;
		n2 = upper_q * upper_q + fore_q * fore_q - rr2;
		r0q = longint'(sqrt_floor(longint'(rr0) << 16));
		a0 = cordic_angle(x, -z);
		a1 = cordic_angle(n1, s) + cordic_angle(r0q, r1 * 256);
		a2 = cordic_angle(n2, s);
		r.base = 19'(clip(round_to_frac(a0), -pi_f, pi_f));
		r.shoulder = 20'(clip(round_to_frac(a1), -round_to_frac(HALF_PI_Q30_L),
			round_to_frac(THREE_HALF_Q30_L)));
		r.elbow = 19'(clip(round_to_frac(a2) - elbow_c, -elbow_c, 0));
		r.status = ST_OK;
		return r;
	endfunction

	assign angles_pending = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		joint_set_t want;
		if (!arst_n) begin
			height_q = 0;
			upper_q = 64'd1 << FRAC_BITS;
			fore_q = 64'd1 << FRAC_BITS;
			angle_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_HEIGHT: height_q = cfg_data;
					REG_UPPER_LINK:  upper_q = cfg_data;
					REG_FOREARM:     fore_q = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (angle_queue.size() == 0) begin
					$error("result transfer with no target outstanding");
					fail_count++;
				end else begin
					want = angle_queue.pop_front();
					if (base_angle !== want.base) begin
						$error("base_angle expected %0d got %0d", want.base, base_angle);
						fail_count++;
					end
					if (shoulder_angle !== want.shoulder) begin
						$error("shoulder_angle expected %0d got %0d",
							want.shoulder, shoulder_angle);
						fail_count++;
					end
					if (elbow_angle !== want.elbow) begin
						$error("elbow_angle expected %0d got %0d", want.elbow, elbow_angle);
						fail_count++;
					end
					if (solve_status !== want.status) begin
						$error("solve_status expected %0d got %0d",
							want.status, solve_status);
						fail_count++;
					end
				end
			end
			// queue the prediction at the tail
			if (in_valid && in_ready)
				angle_queue = {angle_queue, solve_arm(target_x, target_y, target_z)};
		end
	end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the arm inverse kinematics pipeline
// ----------------------------------------------------------------------------
// Runs several link and height settings, all but the last opening with directed
// targets (axes, extremes, singular base, out of reach), each followed by mostly
// reachable random targets and some full-range noise. Sender gaps and receiver
// stalls are drawn per transfer; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tjaik_pkg::*;

	// index past the last register, writes to it must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PIPE_LAT = 92;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic  [1:0]        cfg_index = REG_BASE_HEIGHT;
	logic  [18:0]       cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic  signed [19:0] target_x = '0;
	logic  signed [19:0] target_y = '0;
	logic  signed [19:0] target_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic  signed [18:0] base_angle;
	logic  signed [19:0] shoulder_angle;
	logic  signed [18:0] elbow_angle;
	logic  [1:0]        solve_status;
	int                 fail_count;
	int                 angles_pending;

	// mirror of the link settings, used to aim random targets into reach
	int                 reach_span = 2 * 65536;
	int                 height_now = 0;
	bit                 no_gaps = 1'b0;
	bit                 no_stalls = 1'b0;
	int                 stall_left = 0;
	bit                 took_result = 1'b0;
	int                 cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	three_joint_arm_inverse_kinematics_top uut (.*);

	tjaik_checker chk (.*);

	// receiver: a fresh stall is drawn after each result transfer
	always @(posedge clk)
		took_result <= out_valid && out_ready;

	always @(negedge clk) begin
		int left;
		left = stall_left;
		if (took_result)
			left = no_stalls ? 0 : $urandom_range(0, 12);
		if (left > 0) begin
			out_ready <= 1'b0;
			left--;
		end else begin
			out_ready <= 1'b1;
		end
		stall_left = left;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 19'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one target transfer, with a drawn idle gap in front
	task automatic send_target(input int x, input int y, input int z);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		target_x <= 20'(x);
		target_y <= 20'(y);
		target_z <= 20'(z);
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic lower_valid;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// sender holds off until the pipeline has drained, then config may change
	task automatic drain;
		lower_valid();
		while (angles_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int clamp20(input longint v);
		return (v > 524287) ? 524287 : ((v < -524288) ? -524288 : int'(v));
	endfunction

	function automatic int near(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic set_arm(input int unsigned h, input int unsigned l1, input int unsigned l2);
		write_reg(REG_BASE_HEIGHT, h);
		write_reg(REG_UPPER_LINK, l1);
		write_reg(REG_FOREARM, l2);
		height_now = h;
		reach_span = (l1 + l2 == 0) ? 65536 : int'(l1 + l2);
	endtask

	task automatic directed_targets;
		int l;
		l = reach_span / 2;
		send_target(0, 0, 0);
		send_target(0, 524287, 0);
		send_target(l, height_now, 0);
		send_target(-l, height_now, 0);
		send_target(0, height_now, l);
		send_target(0, height_now, -l);
		send_target(l / 2, height_now + l / 2, l / 3);
		send_target(-l / 2, height_now - l / 2, -l / 3);
		send_target(clamp20(reach_span), height_now, 0);
		send_target(524287, 524287, 524287);
		send_target(-524288, -524288, -524288);
		send_target(-524288, 0, 524287);
		send_target(1, height_now, 0);
		send_target(0, height_now, -1);
		send_target(-1, -524288, 1);
	endtask

	task automatic random_targets(input int n);
		int pick, s;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				no_stalls = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			s = reach_span;
			if (pick < 70)
				send_target(clamp20(near(s)), clamp20(height_now + near(s)),
					clamp20(near(s)));
			else if (pick < 88)
				send_target(int'($urandom()) >>> 12, int'($urandom()) >>> 12,
					int'($urandom()) >>> 12);
			else if (pick < 94)
				send_target(0, clamp20(near(s)), 0);
			else
				send_target(clamp20(near(s)), clamp20(height_now + near(s)), 0);
		end
		no_gaps = 1'b0;
		no_stalls = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: both links 1.0, shoulder on the floor
		directed_targets();
		random_targets(110);
		drain();

		// longest links and highest shoulder
		set_arm(524287, 524287, 524287);
		directed_targets();
		random_targets(90);
		drain();

		// shortest links, reachable shell is very thin
		set_arm(0, 1, 1);
		directed_targets();
		random_targets(40);
		drain();

		// unequal links, random height, stray write to the unused index
		set_arm($urandom_range(0, 200000), $urandom_range(20000, 120000),
			$urandom_range(150000, 524287));
		write_reg(REG_UNUSED, $urandom_range(0, 524287));
		directed_targets();
		random_targets(110);
		drain();

		// zero link: everything but the singular base is out of reach
		set_arm(65536, 0, 65536);
		directed_targets();
		random_targets(15);
		drain();

		set_arm($urandom_range(0, 524287), $urandom_range(1, 524287),
			$urandom_range(1, 524287));
		random_targets(80);
		lower_valid();

		while (angles_pending != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
sv/tjaik_pkg.sv
sv/tjaik_isqrt.sv
sv/tjaik_cordic.sv
sv/three_joint_arm_inverse_kinematics_top.sv
tb/tjaik_checker.sv
tb/tb_top.sv
